// ----- rtl/csbe_pkg.sv -----
// Shared types and command codes for the cubic spline basis evaluator.
`default_nettype none
package csbe_pkg;

    typedef enum logic [2:0] {
        CMD_WR_MESH   = 3'd0,
        CMD_WR_COEF   = 3'd1,
        CMD_WR_SAMPLE = 3'd2,
        CMD_BASIS     = 3'd3,
        CMD_INTERP    = 3'd4
    } cmd_e;

    typedef struct packed {
        logic [2:0]         command;
        logic [4:0]         node_index;
        logic [4:0]         interval_index;
        logic signed [31:0] value;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_quadratic;
        logic signed [31:0] coef_cubic;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [4:0]         basis_number;
        logic               in_range;
        logic               last;
    } out_item_t;

    localparam int RESULT_LIMIT = 32;

endpackage
`default_nettype wire

// ----- rtl/csbe_front.sv -----
// Input stage: accepts beats and holds them in a two-entry queue for the back end.
`default_nettype none
module csbe_front
    import csbe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_data,
    input  wire logic     in_valid,
    output logic          in_ready,
    output in_item_t      q_data,
    output logic          q_valid,
    input  wire logic     q_pop
);
    in_item_t   mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_data.command <= CMD_INTERP);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/csbe_back.sv -----
// Execution engine: store writes, interval search and Horner evaluation on one multiplier.
`default_nettype none
module csbe_back
    import csbe_pkg::*;
#(
    parameter int MAX_POINTS    = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic [5:0] mesh_points,
    input  wire in_item_t q_data,
    input  wire logic     q_valid,
    output logic          q_pop,
    output out_item_t     out_data,
    output logic          out_valid,
    input  wire logic     out_ready
);
    localparam int NW    = $clog2(MAX_POINTS);
    localparam int DEPTH = MAX_POINTS * (MAX_POINTS - 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int NMAX  = (MAX_POINTS < RESULT_LIMIT) ? MAX_POINTS : RESULT_LIMIT;
    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LO    = 11'b00000000010,
        S_HI    = 11'b00000000100,
        S_SRCH  = 11'b00000001000,
        S_SRCH2 = 11'b00000010000,
        S_DIFF  = 11'b00000100000,
        S_RD    = 11'b00001000000,
        S_MUL   = 11'b00010000000,
        S_ACC   = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_WAIT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] mesh_mem [MAX_POINTS];
    logic signed [31:0] samp_mem [MAX_POINTS];
    logic signed [31:0] lin_mem  [DEPTH];
    logic signed [31:0] quad_mem [DEPTH];
    logic signed [31:0] cub_mem  [DEPTH];

    logic signed [31:0] mesh_rd_reg, samp_rd_reg, lin_rd_reg, quad_rd_reg, cub_rd_reg;
    logic [NW-1:0]      mesh_addr;
    logic [AW-1:0]      coef_addr;
    logic [NW-1:0]      wr_node;

    in_item_t           cur_reg;
    logic [5:0]         n_reg;
    logic [5:0]         i_reg;
    logic [NW-1:0]      j_reg;
    logic               found_reg;
    logic               inside_reg;
    logic signed [31:0] lo_reg, prev_reg, d_reg, t_reg;
    logic [1:0]         step_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               obuf_valid_reg;
    out_item_t          obuf_reg;

    logic [5:0] n_sat;
    always_comb
    begin
        n_sat = mesh_points;
        if (n_sat < 6'd3)
        begin
            n_sat = 6'd3;
        end
        if (n_sat > 6'(NMAX))
        begin
            n_sat = 6'(NMAX);
        end
    end

    function automatic logic signed [31:0] sat(input logic signed [63:0] x);
        if (x > SMAX)
        begin
            return 32'sh7fffffff;
        end
        if (x < SMIN)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    logic is_write, q_take;
    assign is_write = (q_data.command == CMD_WR_MESH) || (q_data.command == CMD_WR_COEF)
                      || (q_data.command == CMD_WR_SAMPLE);
    assign q_take = (state_reg == S_IDLE) && q_valid;
    assign q_pop  = q_take;
    assign wr_node = NW'(q_data.node_index);

    // store writes straight from the queue head
    always_ff @(posedge clk)
    begin
        if (q_take && is_write && (32'(q_data.node_index) < MAX_POINTS))
        begin
            if (q_data.command == CMD_WR_MESH)
            begin
                mesh_mem[wr_node] <= q_data.value;
            end
            if (q_data.command == CMD_WR_SAMPLE)
            begin
                samp_mem[wr_node] <= q_data.value;
            end
            if (q_data.command == CMD_WR_COEF && (32'(q_data.interval_index) < MAX_POINTS - 1))
            begin
                lin_mem[AW'(32'(q_data.node_index) * (MAX_POINTS - 1)
                            + 32'(q_data.interval_index))] <= q_data.coef_linear;
                quad_mem[AW'(32'(q_data.node_index) * (MAX_POINTS - 1)
                             + 32'(q_data.interval_index))] <= q_data.coef_quadratic;
                cub_mem[AW'(32'(q_data.node_index) * (MAX_POINTS - 1)
                            + 32'(q_data.interval_index))] <= q_data.coef_cubic;
            end
        end
        mesh_rd_reg <= mesh_mem[mesh_addr];
        samp_rd_reg <= samp_mem[i_reg[NW-1:0]];
        lin_rd_reg  <= lin_mem[coef_addr];
        quad_rd_reg <= quad_mem[coef_addr];
        cub_rd_reg  <= cub_mem[coef_addr];
    end

    // mesh read address: index 0, n-1, the search walk, then mesh[j] per node
    always_comb
    begin
        mesh_addr = i_reg[NW-1:0];
        if (state_reg == S_IDLE)
        begin
            mesh_addr = '0;
        end
        else if (state_reg == S_LO)
        begin
            mesh_addr = NW'(n_reg - 6'd1);
        end
        else if (state_reg == S_DIFF)
        begin
            mesh_addr = j_reg;
        end
    end
    assign coef_addr = AW'(32'(i_reg) * (MAX_POINTS - 1) + 32'(j_reg));

    // 32x32 signed multiplier shared by Horner steps and the sample product
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    always_comb
    begin
        mul_a = d_reg;
        mul_b = t_reg;
        if (step_reg == 2'd0)
        begin
            mul_b = cub_rd_reg;
        end
        else if (step_reg == 2'd3)
        begin
            mul_a = t_reg;
            mul_b = samp_rd_reg;
        end
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    logic signed [63:0] sh;
    assign sh = prod_reg >>> FRACTION_BITS;

    logic out_free, last_node, is_interp, emit_acc, load_obuf;
    assign out_free  = !obuf_valid_reg || out_ready;
    assign last_node = (i_reg == n_reg - 6'd1);
    assign is_interp = (cur_reg.command == CMD_INTERP);
    // interpolate: fold the last weighted sample product into the sum
    assign emit_acc  = inside_reg && is_interp && (step_reg == 2'd3);
    assign load_obuf = out_free && (((state_reg == S_WAIT) && !is_interp)
                                    || ((state_reg == S_EMIT) && !emit_acc));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_take && !is_write) state_next = S_LO;
            S_LO:    state_next = S_HI;
            S_HI:    state_next = S_SRCH;
            S_SRCH:  state_next = inside_reg ? S_SRCH2 : S_EMIT;
            S_SRCH2: if (i_reg >= n_reg || found_reg) state_next = S_DIFF;
            S_DIFF:  state_next = S_RD;
            S_RD:    state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = (step_reg == 2'd2) ? S_WAIT : S_MUL;
            S_WAIT:
            begin
                if (is_interp)
                begin
                    state_next = S_EMIT;
                end
                else if (out_free)
                begin
                    state_next = last_node ? S_IDLE : S_DIFF;
                end
            end
            S_EMIT:
            begin
                if (emit_acc)
                begin
                    state_next = last_node ? S_EMIT : S_DIFF;
                end
                else if (out_free && (is_interp || last_node))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            obuf_valid_reg <= 1'b0;
            i_reg          <= '0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            obuf_valid_reg <= load_obuf || (obuf_valid_reg && !out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_take && !is_write)
                    begin
                        i_reg <= 6'd1;
                    end
                end
                S_HI:
                begin
                    i_reg <= 6'd2;
                end
                S_SRCH:
                begin
                    if (!inside_reg)
                    begin
                        i_reg <= '0;
                    end
                    else if (i_reg < n_reg)
                    begin
                        i_reg <= i_reg + 6'd1;
                    end
                end
                S_SRCH2:
                begin
                    if (i_reg >= n_reg || found_reg)
                    begin
                        i_reg <= '0;
                    end
                    else
                    begin
                        i_reg <= i_reg + 6'd1;
                    end
                end
                S_RD:
                begin
                    step_reg <= 2'd0;
                end
                S_ACC:
                begin
                    step_reg <= step_reg + 2'd1;
                end
                S_WAIT:
                begin
                    if (!is_interp && out_free)
                    begin
                        step_reg <= 2'd0;
                        if (!last_node)
                        begin
                            i_reg <= i_reg + 6'd1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (emit_acc)
                    begin
                        step_reg <= last_node ? 2'd2 : 2'd0;
                        if (!last_node)
                        begin
                            i_reg <= i_reg + 6'd1;
                        end
                    end
                    else if (out_free && !is_interp && !last_node)
                    begin
                        i_reg <= i_reg + 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_take && !is_write)
                begin
                    cur_reg   <= q_data;
                    n_reg     <= n_sat;
                    found_reg <= 1'b0;
                    j_reg     <= '0;
                    acc_reg   <= '0;
                end
            end
            S_LO:
            begin
                lo_reg <= mesh_rd_reg;
            end
            S_HI:
            begin
                inside_reg <= !(cur_reg.value < lo_reg || cur_reg.value > mesh_rd_reg);
            end
            S_SRCH:
            begin
                prev_reg <= mesh_rd_reg;
            end
            S_SRCH2:
            begin
                // mesh_rd_reg holds mesh[i_reg-1], prev_reg holds mesh[i_reg-2]
                if (!found_reg && cur_reg.value >= prev_reg
                    && cur_reg.value <= mesh_rd_reg)
                begin
                    found_reg <= 1'b1;
                    j_reg     <= NW'(i_reg - 6'd2);
                end
                prev_reg <= mesh_rd_reg;
            end
            S_RD:
            begin
                d_reg <= sat(64'(cur_reg.value) - 64'(mesh_rd_reg));
            end
            S_MUL:
            begin
                prod_reg <= mul_p;
            end
            S_ACC:
            begin
                if (step_reg == 2'd0)
                begin
                    t_reg <= sat(64'(quad_rd_reg) + sh);
                end
                else if (step_reg == 2'd1)
                begin
                    t_reg <= sat(64'(lin_rd_reg) + sh);
                end
                else
                begin
                    t_reg <= sat(64'(sat(sh)) + ((NW'(i_reg) == j_reg)
                             ? (64'sd1 <<< FRACTION_BITS) : 64'sd0));
                end
            end
            S_WAIT:
            begin
                // weight in t_reg, times the sample
                if (is_interp)
                begin
                    prod_reg <= mul_p;
                end
            end
            S_EMIT:
            begin
                if (emit_acc)
                begin
                    acc_reg <= acc_reg + sh;
                end
            end
            default: ;
        endcase

        if (load_obuf)
        begin
            if (state_reg == S_WAIT)
            begin
                obuf_reg.result_value <= t_reg;
                obuf_reg.basis_number <= 5'(i_reg);
                obuf_reg.in_range     <= 1'b1;
                obuf_reg.last         <= last_node;
            end
            else if (is_interp)
            begin
                obuf_reg.result_value <= inside_reg ? sat(acc_reg) : '0;
                obuf_reg.basis_number <= '0;
                obuf_reg.in_range     <= inside_reg;
                obuf_reg.last         <= 1'b1;
            end
            else
            begin
                obuf_reg.result_value <= '0;
                obuf_reg.basis_number <= 5'(i_reg);
                obuf_reg.in_range     <= 1'b0;
                obuf_reg.last         <= last_node;
            end
        end
    end

    assign out_valid = obuf_valid_reg;
    assign out_data  = obuf_reg;
endmodule
`default_nettype wire

// ----- rtl/cubic_spline_basis_eval_core.sv -----
// Top level of the cubic spline basis evaluator.
// Usage:
//   cmd channel (cmd_valid/cmd_ready, cmd_data) carries store writes and queries.
//   res channel (res_valid/res_ready, res_data) returns result beats.
//   cfg channel (cfg_valid/cfg_ready, cfg_data) sets the number of mesh points.
// Writes are stored by the back end and give no beat. A basis query gives
// n beats, an interpolate query one beat, last marks the final beat.
// A query runs a bounds check and an interval search, then evaluates each node
// on the single shared multiplier (three Horner products), with one more
// product per node for the sample of an interpolate query and a final sum.
// A point outside the mesh skips the search and the evaluation.
// A two-beat queue decouples command intake from the engine; the result
// register lets the engine continue while a beat waits. When the receiver
// stalls, the engine holds and the queue fills, then cmd_ready drops.
// Reset clears control state and sets the mesh point count to 32; stores keep
// undefined content until written. Commands 5 to 7 are dropped at intake.
`default_nettype none
module cubic_spline_basis_eval_core
    import csbe_pkg::*;
#(
    parameter int MAX_POINTS    = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  cmd_data,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    output out_item_t      res_data,
    output logic           res_valid,
    input  wire logic      res_ready,
    input  wire logic [5:0] cfg_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready
);
    logic [5:0] mesh_points_reg;
    in_item_t   q_data;
    logic       q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_points_reg <= 6'd32;
        end
        else if (cfg_valid)
        begin
            mesh_points_reg <= cfg_data;
        end
    end

    csbe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (cmd_data),
        .in_valid (cmd_valid),
        .in_ready (cmd_ready),
        .q_data   (q_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    csbe_back #(
        .MAX_POINTS    (MAX_POINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mesh_points (mesh_points_reg),
        .q_data      (q_data),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .out_data    (res_data),
        .out_valid   (res_valid),
        .out_ready   (res_ready)
    );
endmodule
`default_nettype wire

// ----- rtl/csbe_checker.sv -----
// Port-level checker for the spline evaluator, bound to the top level.
`default_nettype none
module csbe_checker
    import csbe_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire in_item_t  cmd_data,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire out_item_t res_data,
    input wire logic      res_valid,
    input wire logic      res_ready
);
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_data))
        else $error("command beat changed while stalled");

    a_interp_num: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.in_range && res_data.result_value != 32'sd0 |-> 1'b0)
        else $error("out-of-range result is not zero");

    a_ready_reset: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");
endmodule

bind cubic_spline_basis_eval_core csbe_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_data  (res_data),
    .res_valid (res_valid),
    .res_ready (res_ready)
);
`default_nettype wire
